@@ hdl/escaped_channel_frame_decoder_top_defines.svh @@
// Assertion macros for the checker file.
`ifndef ESCAPED_CHANNEL_FRAME_DECODER_TOP_DEFINES_SVH
`define ESCAPED_CHANNEL_FRAME_DECODER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define ECFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ECFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ecfd_pkg.sv @@
`timescale 1ns / 1ps

package ecfd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] cfg_idx_t;
  typedef logic [3:0] count_t;
  typedef logic signed [15:0] chan_t;

  localparam cfg_idx_t CFG_HEADER_VALUE = 3'd0;
  localparam cfg_idx_t CFG_FOOTER_VALUE = 3'd1;
  localparam cfg_idx_t CFG_ESCAPE_VALUE = 3'd2;
  localparam cfg_idx_t CFG_ESCAPE_XOR_MASK = 3'd3;
  localparam cfg_idx_t CFG_FAILSAFE_BIT_MASK = 3'd4;

  localparam byte_t HEADER_RESET = 8'd126;
  localparam byte_t FOOTER_RESET = 8'd127;
  localparam byte_t ESCAPE_RESET = 8'd125;
  localparam byte_t XOR_MASK_RESET = 8'd32;
  localparam byte_t FAILSAFE_MASK_RESET = 8'd1;

  localparam int FRAME_BYTES = 7;
  localparam count_t FRAME_COUNT = 4'd7;
  localparam count_t COUNT_CEILING = 4'd8;

endpackage

@@ hdl/escaped_channel_frame_decoder_top.sv @@
`timescale 1ns / 1ps

// A result reaches out_valid through the input register and the result register once the
// footer word is accepted. Throughput: one word per cycle while no held result (out_valid
// with out_stall) stalls the input, set by the single decode pass between the two registers.
// Reset (rst_n low, synchronous) closes any frame, clears the escape flag and the count,
// empties both registers and restores the default header, footer, escape and mask values.
module escaped_channel_frame_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ecfd_pkg::byte_t   in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output ecfd_pkg::chan_t   out_channel_a,
  output ecfd_pkg::chan_t   out_channel_b,
  output ecfd_pkg::chan_t   out_channel_c,
  output logic              out_failsafe_flag,
  input  logic              cfg_we,
  input  ecfd_pkg::cfg_idx_t cfg_index,
  input  ecfd_pkg::byte_t   cfg_data
);
  import ecfd_pkg::*;

  byte_t header_r, footer_r, escape_r, xor_mask_r, fs_mask_r;

  logic  s1_valid_r;
  byte_t s1_byte_r;

  logic   frame_open_r, frame_open_nxt;
  logic   esc_pending_r, esc_pending_nxt;
  count_t count_r, count_nxt;
  byte_t  store_r [FRAME_BYTES];

  logic   advance;
  logic   emit;
  logic   store_we;
  byte_t  data;

  logic   out_valid_r, out_valid_nxt;
  chan_t  chan_a_r, chan_b_r, chan_c_r;
  logic   failsafe_r;

  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r   <= HEADER_RESET;
      footer_r   <= FOOTER_RESET;
      escape_r   <= ESCAPE_RESET;
      xor_mask_r <= XOR_MASK_RESET;
      fs_mask_r  <= FAILSAFE_MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_VALUE:      header_r   <= cfg_data;
        CFG_FOOTER_VALUE:      footer_r   <= cfg_data;
        CFG_ESCAPE_VALUE:      escape_r   <= cfg_data;
        CFG_ESCAPE_XOR_MASK:   xor_mask_r <= cfg_data;
        CFG_FAILSAFE_BIT_MASK: fs_mask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_comb begin
    frame_open_nxt  = frame_open_r;
    esc_pending_nxt = esc_pending_r;
    count_nxt       = count_r;
    emit            = 1'b0;
    store_we        = 1'b0;
    data            = esc_pending_r ? (s1_byte_r ^ xor_mask_r) : s1_byte_r;
    if (advance) begin
      priority if (s1_byte_r == header_r) begin
        frame_open_nxt  = 1'b1;
        esc_pending_nxt = 1'b0;
        count_nxt       = '0;
      end else if (s1_byte_r == footer_r) begin
        if (frame_open_r) begin
          emit            = (count_r == FRAME_COUNT);
          frame_open_nxt  = 1'b0;
          esc_pending_nxt = 1'b0;
          count_nxt       = '0;
        end
      end else if (frame_open_r) begin
        if (!esc_pending_r && s1_byte_r == escape_r) begin
          esc_pending_nxt = 1'b1;
        end else begin
          esc_pending_nxt = 1'b0;
          store_we        = (count_r < FRAME_COUNT);
          if (count_r < COUNT_CEILING) begin
            count_nxt = count_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      esc_pending_r <= 1'b0;
      count_r       <= '0;
    end else begin
      frame_open_r  <= frame_open_nxt;
      esc_pending_r <= esc_pending_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[2:0]] <= data;
    end
  end

  always_comb begin
    if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      chan_a_r   <= {store_r[0], store_r[1]};
      chan_b_r   <= {store_r[2], store_r[3]};
      chan_c_r   <= {store_r[4], store_r[5]};
      failsafe_r <= |(store_r[6] & fs_mask_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_a     = chan_a_r;
  assign out_channel_b     = chan_b_r;
  assign out_channel_c     = chan_c_r;
  assign out_failsafe_flag = failsafe_r;

endmodule

@@ hdl/ecfd_checker.sv @@
`timescale 1ns / 1ps
`include "escaped_channel_frame_decoder_top_defines.svh"

module ecfd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input ecfd_pkg::chan_t out_channel_a,
  input ecfd_pkg::chan_t out_channel_b,
  input ecfd_pkg::chan_t out_channel_c,
  input logic            out_failsafe_flag
);
  import ecfd_pkg::*;

  logic        out_held;
  logic [48:0] out_word;

  assign out_held = out_valid && out_stall;
  assign out_word = {out_channel_a, out_channel_b, out_channel_c, out_failsafe_flag};

  `ECFD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result word survived reset")
  `ECFD_ASSERT_ALWAYS(a_reset_clears_stall, !rst_n |=> !in_stall, "input stalled after reset")
  `ECFD_ASSERT(a_stall_needs_blocked_out, in_stall |-> out_held, "stall without a held word")
  `ECFD_ASSERT(a_held_result_stable, out_held |=> out_valid && $stable(out_word), "held word moved")

endmodule

bind escaped_channel_frame_decoder_top ecfd_checker u_ecfd_checker (.*);
